FILE: rtl/dprne_pkg.sv
// shared types, constants and the square root step for the depth point noise estimator
package dprne_pkg;

   // field widths
   localparam int COORD_W  = 16;
   localparam int SQ_W     = 31;
   localparam int SUM_W    = 32;
   localparam int RANGE_W  = 16;
   localparam int STD_W    = 18;
   localparam int SLOPE_W  = 8;
   localparam int PROD_W   = RANGE_W + SLOPE_W;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 18;

   // square root pipeline shape
   localparam int ISQ_STAGES = 8;
   localparam int ISQ_STEPS  = 2;
   localparam int REM_W      = RANGE_W + 1;

   // slope used outside the good band
   localparam logic [SLOPE_W-1:0] BAD_SLOPE = 8'd20;
   localparam logic [STD_W-1:0]   STD_MAX   = '1;

   // register reset values
   localparam logic [15:0] NEAR_CUTOFF_RST = 16'd100;
   localparam logic [15:0] GOOD_LOW_RST    = 16'd500;
   localparam logic [15:0] BEST_RANGE_RST  = 16'd1000;
   localparam logic [15:0] GOOD_HIGH_RST   = 16'd4000;
   localparam logic [15:0] FAR_CUTOFF_RST  = 16'd6000;
   localparam logic [17:0] BASE_GOOD_RST   = 18'd1000;
   localparam logic [17:0] BASE_BAD_RST    = 18'd50000;
   localparam logic [7:0]  GOOD_SLOPE_RST  = 8'd10;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_CUTOFF = 3'd0,
      CSR_GOOD_LOW    = 3'd1,
      CSR_BEST_RANGE  = 3'd2,
      CSR_GOOD_HIGH   = 3'd3,
      CSR_FAR_CUTOFF  = 3'd4,
      CSR_BASE_GOOD   = 3'd5,
      CSR_BASE_BAD    = 3'd6,
      CSR_GOOD_SLOPE  = 3'd7
   } csr_index_type;

   // zone codes
   typedef enum logic [1:0] {
      ZONE_GOOD      = 2'd0,
      ZONE_OUTSIDE   = 2'd1,
      ZONE_NO_RANGE  = 2'd2
   } zone_type;

   // partial state of the digit-by-digit square root
   typedef struct packed {
      logic [SUM_W-1:0]   rad;
      logic [REM_W-1:0]   rem;
      logic [RANGE_W-1:0] root;
   } isq_state_type;

   // one result bit of the restoring square root
   function automatic isq_state_type isq_step(input isq_state_type s);
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] sub;
      logic [REM_W+1:0] diff;
      isq_state_type    n;
      trial = {s.rem, s.rad[SUM_W-1 -: 2]};
      sub   = {1'b0, s.root, 2'b01};
      diff  = trial - sub;
      n.rad = {s.rad[SUM_W-3:0], 2'b00};
      if (trial >= sub) begin
         n.rem  = diff[REM_W-1:0];
         n.root = {s.root[RANGE_W-2:0], 1'b1};
      end else begin
         n.rem  = trial[REM_W-1:0];
         n.root = {s.root[RANGE_W-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

FILE: rtl/depth_point_range_noise_estimator_unit.sv
// top level: range and noise estimate for one depth point per transfer
//
// Takes one point (x, y, z in signed mm) per cycle and returns its range, the floor square root
// of x*x + y*y + z*z, with a noise standard deviation in micrometres and its zone. Throughput is
// one point per cycle while no result stall backs up to the input; the result is shown after
// squares, sum, eight square root stages of two result bits each, classification, slope
// multiply, and the saturating add in the output register. A stall on the result side fills
// empty stages first, so input is still taken while a result waits. Registers must be written
// through the csr port only while no point is in flight; the block itself does not enforce this.
module depth_point_range_noise_estimator_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic                                csr_we,
   input  logic [dprne_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [dprne_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // point input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_mm [15:0], y_mm [31:16], z_mm [47:32]
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // range_mm [15:0], stddev_um [33:16], zone [35:34], zero
);

   localparam int RW = dprne_pkg::RANGE_W;
   localparam int SW = dprne_pkg::STD_W;

   // configuration registers
   logic [15:0] near_ff, good_low_ff, best_ff, good_high_ff, far_ff;
   logic [SW-1:0] base_good_ff, base_bad_ff;
   logic [dprne_pkg::SLOPE_W-1:0] slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff      <= dprne_pkg::NEAR_CUTOFF_RST;
         good_low_ff  <= dprne_pkg::GOOD_LOW_RST;
         best_ff      <= dprne_pkg::BEST_RANGE_RST;
         good_high_ff <= dprne_pkg::GOOD_HIGH_RST;
         far_ff       <= dprne_pkg::FAR_CUTOFF_RST;
         base_good_ff <= dprne_pkg::BASE_GOOD_RST;
         base_bad_ff  <= dprne_pkg::BASE_BAD_RST;
         slope_ff     <= dprne_pkg::GOOD_SLOPE_RST;
      end else if (csr_we) begin
         case (dprne_pkg::csr_index_type'(csr_addr))
            dprne_pkg::CSR_NEAR_CUTOFF: near_ff      <= csr_wdata[15:0];
            dprne_pkg::CSR_GOOD_LOW:    good_low_ff  <= csr_wdata[15:0];
            dprne_pkg::CSR_BEST_RANGE:  best_ff      <= csr_wdata[15:0];
            dprne_pkg::CSR_GOOD_HIGH:   good_high_ff <= csr_wdata[15:0];
            dprne_pkg::CSR_FAR_CUTOFF:  far_ff       <= csr_wdata[15:0];
            dprne_pkg::CSR_BASE_GOOD:   base_good_ff <= csr_wdata[SW-1:0];
            dprne_pkg::CSR_BASE_BAD:    base_bad_ff  <= csr_wdata[SW-1:0];
            dprne_pkg::CSR_GOOD_SLOPE:  slope_ff     <= csr_wdata[dprne_pkg::SLOPE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and stall chain
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic s1_en, s2_en, s3_en, s4_en, s5_en;
   logic isq_in_ready, isq_out_valid;
   logic [RW-1:0] isq_root;

   assign s5_en = !s5_v_ff || rsp_tready;
   assign s4_en = !s4_v_ff || s5_en;
   assign s3_en = !s3_v_ff || s4_en;
   assign s2_en = !s2_v_ff || isq_in_ready;
   assign s1_en = !s1_v_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s1_en) s1_v_ff <= req_tvalid;
         if (s2_en) s2_v_ff <= s1_v_ff;
         if (s3_en) s3_v_ff <= isq_out_valid;
         if (s4_en) s4_v_ff <= s3_v_ff;
         if (s5_en) s5_v_ff <= s4_v_ff;
      end
   end

   // stage 1: squares
   logic signed [15:0] x_mm, y_mm, z_mm;
   logic signed [31:0] xx_in, yy_in, zz_in;
   logic [dprne_pkg::SQ_W-1:0] xx_ff, yy_ff, zz_ff;

   assign x_mm  = req_tdata[15:0];
   assign y_mm  = req_tdata[31:16];
   assign z_mm  = req_tdata[47:32];
   assign xx_in = x_mm * x_mm;
   assign yy_in = y_mm * y_mm;
   assign zz_in = z_mm * z_mm;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         xx_ff <= xx_in[dprne_pkg::SQ_W-1:0];
         yy_ff <= yy_in[dprne_pkg::SQ_W-1:0];
         zz_ff <= zz_in[dprne_pkg::SQ_W-1:0];
      end
   end

   // stage 2: sum of squares, fits 32 bits
   logic [dprne_pkg::SUM_W-1:0] sum_in, sum_ff;
   assign sum_in = {1'b0, xx_ff} + {1'b0, yy_ff} + {1'b0, zz_ff};

   always_ff @(posedge clock) begin
      if (s2_en) sum_ff <= sum_in;
   end

   // square root pipeline
   dprne_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_v_ff),
      .in_ready    (isq_in_ready),
      .in_radicand (sum_ff),
      .out_valid   (isq_out_valid),
      .out_ready   (s3_en),
      .out_root    (isq_root)
   );

   // stage 3: zone, deviation from best range, base and slope selection
   dprne_pkg::zone_type zone_in, s3_zone_ff, s4_zone_ff, s5_zone_ff;
   logic [RW-1:0] dev_in, s3_dev_ff;
   logic [RW-1:0] s3_range_ff, s4_range_ff, s5_range_ff;
   logic [SW-1:0] base_in, s3_base_ff, s4_base_ff;
   logic [dprne_pkg::SLOPE_W-1:0] slope_in, s3_slope_ff;

   always_comb begin
      dev_in = (isq_root >= best_ff) ? isq_root - best_ff : best_ff - isq_root;
      if (isq_root < near_ff || isq_root > far_ff) begin
         zone_in  = dprne_pkg::ZONE_NO_RANGE;
         base_in  = base_bad_ff;
         slope_in = dprne_pkg::BAD_SLOPE;
      end else if (isq_root < good_low_ff || isq_root > good_high_ff) begin
         zone_in  = dprne_pkg::ZONE_OUTSIDE;
         base_in  = base_bad_ff;
         slope_in = dprne_pkg::BAD_SLOPE;
      end else begin
         zone_in  = dprne_pkg::ZONE_GOOD;
         base_in  = base_good_ff;
         slope_in = slope_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_zone_ff  <= zone_in;
         s3_dev_ff   <= dev_in;
         s3_range_ff <= isq_root;
         s3_base_ff  <= base_in;
         s3_slope_ff <= slope_in;
      end
   end

   // stage 4: deviation times slope
   logic [dprne_pkg::PROD_W-1:0] prod_in, s4_prod_ff;
   assign prod_in = s3_dev_ff * s3_slope_ff;

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_zone_ff  <= s3_zone_ff;
         s4_range_ff <= s3_range_ff;
         s4_base_ff  <= s3_base_ff;
         s4_prod_ff  <= prod_in;
      end
   end

   // stage 5: saturating add into the output register, or the maximum for points out of range
   logic [dprne_pkg::PROD_W:0] total_in;
   logic [SW-1:0] std_in, s5_std_ff;

   always_comb begin
      total_in = {{(dprne_pkg::PROD_W + 1 - SW){1'b0}}, s4_base_ff} + {1'b0, s4_prod_ff};
      if (s4_zone_ff == dprne_pkg::ZONE_NO_RANGE || total_in[dprne_pkg::PROD_W:SW] != '0) begin
         std_in = dprne_pkg::STD_MAX;
      end else begin
         std_in = total_in[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_zone_ff  <= s4_zone_ff;
         s5_range_ff <= s4_range_ff;
         s5_std_ff   <= std_in;
      end
   end

   assign rsp_tvalid = s5_v_ff;
   assign rsp_tdata  = {4'b0000, s5_zone_ff, s5_std_ff, s5_range_ff};

endmodule

FILE: rtl/dprne_isqrt.sv
// pipelined floor square root of a 32 bit sum, two result bits per stage
module dprne_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [dprne_pkg::SUM_W-1:0]  in_radicand,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [dprne_pkg::RANGE_W-1:0] out_root
);

   localparam int N = dprne_pkg::ISQ_STAGES;

   logic                     v_ff  [N];
   dprne_pkg::isq_state_type st_ff [N];
   dprne_pkg::isq_state_type st_in [N];
   logic                     v_src [N];
   logic                     en    [N];

   // stall chain: a stage loads when empty or when its successor loads
   always_comb begin
      en[N-1] = !v_ff[N-1] || out_ready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   // next state of every stage
   always_comb begin
      dprne_pkg::isq_state_type s;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            s.rad  = in_radicand;
            s.rem  = '0;
            s.root = '0;
            v_src[k] = in_valid;
         end else begin
            s = st_ff[k-1];
            v_src[k] = v_ff[k-1];
         end
         for (int j = 0; j < dprne_pkg::ISQ_STEPS; j++) begin
            s = dprne_pkg::isq_step(s);
         end
         st_in[k] = s;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_src[k];
         end
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[N-1];
   assign out_root  = st_ff[N-1].root;

endmodule

FILE: dv/testbench.sv
// testbench for the depth point range and noise estimator: directed table, then random points
`timescale 1ns / 1ps

module testbench;

   localparam int PHASE_POINTS = 103;
   localparam int MAX_RANGE    = 56755;
   localparam int DRAIN_CYCLES = 20;

   // one result as it sits in rsp_tdata, lowest field last
   typedef struct packed {
      dprne_pkg::zone_type           zone;
      logic [dprne_pkg::STD_W-1:0]   stddev_um;
      logic [dprne_pkg::RANGE_W-1:0] range_mm;
   } estimate_type;

   typedef struct {
      logic signed [dprne_pkg::COORD_W-1:0] x, y, z;
      bit                                   known;
      estimate_type                         res;
   } point_row_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [dprne_pkg::CSR_IDX_W-1:0]  csr_addr;
   logic [dprne_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [47:0]                      req_tdata;   // x_mm [15:0], y_mm [31:16], z_mm [47:32]
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // range_mm [15:0], stddev_um [33:16], zone [35:34], zero
   logic [39:0]                      rsp_tdata;

   // register copy used for prediction
   logic [15:0] near_mm, low_mm, best_mm, high_mm, far_mm;
   logic [17:0] base_good, base_bad;
   logic [7:0]  slope;

   estimate_type pending_estimates[$];
   int           mismatch_count = 0;
   bit           quiet = 1'b0;

   // extremes and zone edges at reset settings; typed-in results where obvious
   point_row_type directed_points[20] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1,
        '{dprne_pkg::ZONE_NO_RANGE, dprne_pkg::STD_MAX, 16'd0}},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1,
        '{dprne_pkg::ZONE_NO_RANGE, dprne_pkg::STD_MAX, 16'd56755}},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, 16'sd0, 16'sd0, 1'b1,
        '{dprne_pkg::ZONE_NO_RANGE, dprne_pkg::STD_MAX, 16'd32768}},
      '{16'sd0, 16'sd0, 16'sd99, 1'b1,
        '{dprne_pkg::ZONE_NO_RANGE, dprne_pkg::STD_MAX, 16'd99}},
      '{16'sd1000, 16'sd0, 16'sd0, 1'b1, '{dprne_pkg::ZONE_GOOD, 18'd1000, 16'd1000}},
      '{16'sd0, -16'sd1000, 16'sd0, 1'b1, '{dprne_pkg::ZONE_GOOD, 18'd1000, 16'd1000}},
      '{16'sd0, 16'sd0, 16'sd100, 1'b0, '0},
      '{16'sd499, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd500, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd0, -16'sd4000, 1'b0, '0},
      '{16'sd4001, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd6000, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd6001, 1'b1,
        '{dprne_pkg::ZONE_NO_RANGE, dprne_pkg::STD_MAX, 16'd6001}},
      '{16'sd3, 16'sd4, 16'sd12, 1'b0, '0},
      '{16'sd1, -16'sd1, 16'sd1, 1'b0, '0},
      '{16'sd707, 16'sd707, 16'sd0, 1'b0, '0},
      '{16'sd577, -16'sd577, 16'sd577, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 16'sd0, 1'b0, '0},
      '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '0}
   };

   depth_point_range_noise_estimator_unit DUT (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor square root, one result bit per pass
   function automatic logic [15:0] floor_sqrt(input logic [63:0] n);
      logic [15:0] root;
      logic [15:0] cand;
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         cand = root | (16'd1 << b);
         if (64'(cand) * 64'(cand) <= n)
            root = cand;
      end
      return root;
   endfunction

   // range, zone and saturated noise estimate of one point
   function automatic estimate_type predict_noise(input logic signed [15:0] x, y, z);
      longint       sum_sq;
      logic [15:0]  rng;
      logic [15:0]  dev;
      logic [63:0]  sd;
      estimate_type e;
      sum_sq = longint'(x) * longint'(x) + longint'(y) * longint'(y) +
               longint'(z) * longint'(z);
      rng    = floor_sqrt(sum_sq);
      dev    = (rng >= best_mm) ? rng - best_mm : best_mm - rng;
      if (rng < near_mm || rng > far_mm) begin
         sd     = 64'(dprne_pkg::STD_MAX);
         e.zone = dprne_pkg::ZONE_NO_RANGE;
      end else if (rng < low_mm || rng > high_mm) begin
         sd     = 64'(base_bad) + 64'(dev) * 64'(dprne_pkg::BAD_SLOPE);
         e.zone = dprne_pkg::ZONE_OUTSIDE;
      end else begin
         sd     = 64'(base_good) + 64'(dev) * 64'(slope);
         e.zone = dprne_pkg::ZONE_GOOD;
      end
      if (sd > 64'(dprne_pkg::STD_MAX))
         sd = 64'(dprne_pkg::STD_MAX);
      e.range_mm  = rng;
      e.stddev_um = sd[dprne_pkg::STD_W-1:0];
      return e;
   endfunction

   function automatic int draw_gap();
      if (quiet)
         return 0;
      return $urandom_range(0, 15);
   endfunction

   task automatic log_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%t: %s", $realtime, what);
   endtask

   // one point transfer; valid stays high when the next one follows at once
   task automatic send_point(input logic signed [15:0] x, y, z, input bit known,
                             input estimate_type res);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pending_estimates.push_back(known ? res : predict_noise(x, y, z));
   endtask

   // spread a target range over the three axes, random signs and axis order
   task automatic make_point(input int r, output logic signed [15:0] x, y, z);
      longint      rest;
      logic [15:0] a[3];
      int          rot;
      rest = longint'(r) * longint'(r);
      for (int i = 0; i < 3; i++) begin
         a[i] = floor_sqrt(rest);
         if (a[i] > 16'd32767)
            a[i] = 16'd32767;
         rest -= longint'(a[i]) * longint'(a[i]);
      end
      rot = $urandom_range(0, 2);
      x = a[rot];
      y = a[(rot + 1) % 3];
      z = a[(rot + 2) % 3];
      if ($urandom_range(0, 1)) x = -x;
      if ($urandom_range(0, 1)) y = -y;
      if ($urandom_range(0, 1)) z = -z;
   endtask

   // mostly points near a zone edge, some short vectors, some raw noise
   task automatic send_random_point();
      int                 mode;
      int                 thr;
      int                 r;
      logic signed [15:0] x, y, z;
      mode = $urandom_range(0, 19);
      if (mode < 12) begin
         case ($urandom_range(0, 4))
            0:       thr = int'(near_mm);
            1:       thr = int'(low_mm);
            2:       thr = int'(best_mm);
            3:       thr = int'(high_mm);
            default: thr = int'(far_mm);
         endcase
         r = thr + int'($urandom_range(0, 6)) - 3;
         if (r < 0)
            r = 0;
         if (r > MAX_RANGE)
            r = int'($urandom_range(0, MAX_RANGE));
         make_point(r, x, y, z);
      end else if (mode < 15) begin
         x = 16'($urandom_range(0, 400) - 200);
         y = 16'($urandom_range(0, 400) - 200);
         z = 16'($urandom_range(0, 400) - 200);
      end else begin
         x = 16'($urandom());
         y = 16'($urandom());
         z = 16'($urandom());
      end
      send_point(x, y, z, 1'b0, '0);
   endtask

   task automatic run_points(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 31) == 0)
            quiet = !quiet;
         send_random_point();
      end
   endtask

   // register write, the copy keeps only the register's width
   task automatic write_register(input dprne_pkg::csr_index_type idx,
                                 input logic [17:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         dprne_pkg::CSR_NEAR_CUTOFF: near_mm   = value[15:0];
         dprne_pkg::CSR_GOOD_LOW:    low_mm    = value[15:0];
         dprne_pkg::CSR_BEST_RANGE:  best_mm   = value[15:0];
         dprne_pkg::CSR_GOOD_HIGH:   high_mm   = value[15:0];
         dprne_pkg::CSR_FAR_CUTOFF:  far_mm    = value[15:0];
         dprne_pkg::CSR_BASE_GOOD:   base_good = value;
         dprne_pkg::CSR_BASE_BAD:    base_bad  = value;
         dprne_pkg::CSR_GOOD_SLOPE:  slope     = value[7:0];
         default: ;
      endcase
   endtask

   // drain the pipe, then rewrite every register
   task automatic load_settings(input logic [17:0] near, low, best, high, far,
                                input logic [17:0] good_um, bad_um, slope_um);
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(dprne_pkg::CSR_NEAR_CUTOFF, near);
      write_register(dprne_pkg::CSR_GOOD_LOW, low);
      write_register(dprne_pkg::CSR_BEST_RANGE, best);
      write_register(dprne_pkg::CSR_GOOD_HIGH, high);
      write_register(dprne_pkg::CSR_FAR_CUTOFF, far);
      write_register(dprne_pkg::CSR_BASE_GOOD, good_um);
      write_register(dprne_pkg::CSR_BASE_BAD, bad_um);
      write_register(dprne_pkg::CSR_GOOD_SLOPE, slope_um);
      csr_we <= 1'b0;
      quiet = ($urandom_range(0, 3) == 0);
   endtask

   // random edges, sorted into zone order or left scrambled with junk upper bits
   task automatic random_settings(input bit ordered);
      int t[$];
      int top;
      top = $urandom_range(200, 60000);
      repeat (5) t.push_back($urandom_range(0, top));
      if (ordered)
         t.sort();
      else
         foreach (t[i]) t[i] = t[i] | ($urandom_range(0, 3) << 16);
      load_settings(18'(t[0]), 18'(t[1]), 18'(t[2]), 18'(t[3]), 18'(t[4]),
                    18'($urandom_range(0, 262143)), 18'($urandom_range(0, 262143)),
                    18'($urandom_range(0, 1023)));
   endtask

   // result side: random stalls, each transfer checked against the oldest estimate
   initial begin : result_sink
      int           gap;
      estimate_type got;
      estimate_type want;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         got = estimate_type'(rsp_tdata[35:0]);
         if (pending_estimates.size() == 0) begin
            log_failure($sformatf("unexpected result range %0d stddev %0d zone %0d",
                                  got.range_mm, got.stddev_um, got.zone));
         end else begin
            want = pending_estimates.pop_front();
            if (got.range_mm !== want.range_mm || got.stddev_um !== want.stddev_um ||
                got.zone !== want.zone || rsp_tdata[39:36] !== 4'd0)
               log_failure($sformatf(
                  "mismatch: expected range %0d stddev %0d zone %0d, got %0d %0d %0d pad %h",
                  want.range_mm, want.stddev_um, want.zone,
                  got.range_mm, got.stddev_um, got.zone, rsp_tdata[39:36]));
         end
      end
   end

   // stimulus and register phases
   initial begin : point_source
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_addr   <= dprne_pkg::CSR_NEAR_CUTOFF;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      near_mm    = dprne_pkg::NEAR_CUTOFF_RST;
      low_mm     = dprne_pkg::GOOD_LOW_RST;
      best_mm    = dprne_pkg::BEST_RANGE_RST;
      high_mm    = dprne_pkg::GOOD_HIGH_RST;
      far_mm     = dprne_pkg::FAR_CUTOFF_RST;
      base_good  = dprne_pkg::BASE_GOOD_RST;
      base_bad   = dprne_pkg::BASE_BAD_RST;
      slope      = dprne_pkg::GOOD_SLOPE_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_points[i])
         send_point(directed_points[i].x, directed_points[i].y, directed_points[i].z,
                    directed_points[i].known, directed_points[i].res);
      run_points(PHASE_POINTS);

      // everything zero: only the origin stays in range
      load_settings('0, '0, '0, '0, '0, '0, '0, '0);
      run_points(PHASE_POINTS);

      // huge bases and slope, sums saturate in both bands
      load_settings(18'd0, 18'd30000, 18'd0, 18'd65535, 18'd65535, 18'd250000,
                    18'd262143, 18'd255);
      run_points(PHASE_POINTS);

      // all ones everywhere, upper bits dropped by the narrow registers
      load_settings('1, '1, '1, '1, '1, '1, '1, '1);
      run_points(PHASE_POINTS);

      repeat (2) begin
         random_settings(1'b0);
         run_points(PHASE_POINTS);
      end
      repeat (4) begin
         random_settings(1'b1);
         run_points(PHASE_POINTS);
      end

      load_settings(18'(dprne_pkg::NEAR_CUTOFF_RST), 18'(dprne_pkg::GOOD_LOW_RST),
                    18'(dprne_pkg::BEST_RANGE_RST), 18'(dprne_pkg::GOOD_HIGH_RST),
                    18'(dprne_pkg::FAR_CUTOFF_RST), dprne_pkg::BASE_GOOD_RST,
                    dprne_pkg::BASE_BAD_RST, 18'(dprne_pkg::GOOD_SLOPE_RST));
      run_points(PHASE_POINTS);

      // drain and let any stray result show up
      req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_estimates.size() == 0)
         $display("[depth_point_range_noise_estimator_unit] OK");
      else
         $display("[depth_point_range_noise_estimator_unit] ERROR");
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("[depth_point_range_noise_estimator_unit] ERROR");
      $finish;
   end

endmodule
